>>> rtl/shannon_entropy_accumulator_macros.svh
// assertion macros for the entropy accumulator
`ifndef SHANNON_ENTROPY_ACCUMULATOR_MACROS_SVH
`define SHANNON_ENTROPY_ACCUMULATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SEA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sea assertion failed");

// next-cycle implication
`define SEA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sea assertion failed");

`else

`define SEA_ASSERT_IMP(label, clk, rst, ante, cons)
`define SEA_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/sea_pkg.sv
package sea_pkg;

  localparam int PROB_FRAC_BITS   = 16;
  localparam int LOG_TABLE_BITS   = 8;
  localparam int ENTROPY_INT_BITS = 8;

  localparam int PROB_W     = PROB_FRAC_BITS + 1;
  localparam int TBL_SIZE   = 1 << LOG_TABLE_BITS;
  localparam int LOG_FRAC   = 16;
  localparam int ENT_W      = ENTROPY_INT_BITS + LOG_FRAC;
  localparam int SUM_W      = ENT_W + 1;
  localparam int EXP_W      = $clog2(PROB_FRAC_BITS + 1);
  localparam int NEGLOG_W   = EXP_W + LOG_FRAC;
  localparam int PROD_W     = PROB_FRAC_BITS + NEGLOG_W;
  localparam int NORM_W     = PROB_FRAC_BITS + LOG_TABLE_BITS;
  localparam int LOG_EXTRA  = 24;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [PROB_W-1:0] probability;
    logic              last_entry;
  } sea_in_t;

  typedef struct packed {
    logic [ENT_W-1:0] entropy;
    logic             saturated;
  } sea_out_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [PROB_FRAC_BITS-1:0] prob;
    logic [EXP_W-1:0]          int_part;
    logic [LOG_TABLE_BITS-1:0] idx;
    logic                      last;
  } sea_work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sea_q_stat_t;

  typedef logic [LOG_FRAC-1:0] sea_log_tbl_t [TBL_SIZE];

  // round(log2(1 + k/2^LOG_TABLE_BITS) * 2^16) by repeated squaring
  function automatic logic [LOG_FRAC-1:0] log_entry(int unsigned k);
    logic [63:0]          x;
    logic [127:0]         sq;
    logic [LOG_EXTRA-1:0] r;
    logic [LOG_EXTRA:0]   rr;
    x = (64'd1 << 62) + (64'(k) << (62 - LOG_TABLE_BITS));
    r = '0;
    for (int i = 0; i < LOG_EXTRA; i++) begin
      sq = 128'(x) * 128'(x);
      x  = sq[125:62];
      r  = {r[LOG_EXTRA-2:0], 1'b0};
      if (x[63]) begin
        r[0] = 1'b1;
        x    = x >> 1;
      end
    end
    rr = ((LOG_EXTRA+1)'(r) + ((LOG_EXTRA+1)'(1) << (LOG_EXTRA - 17))) >> (LOG_EXTRA - 16);
    if (rr > (LOG_EXTRA+1)'(16'hFFFF)) begin
      rr = (LOG_EXTRA+1)'(16'hFFFF);
    end
    return rr[LOG_FRAC-1:0];
  endfunction

  function automatic sea_log_tbl_t build_log_table();
    sea_log_tbl_t t;
    for (int k = 0; k < TBL_SIZE; k++) begin
      t[k] = log_entry(k);
    end
    return t;
  endfunction

  localparam sea_log_tbl_t LOG_TABLE = build_log_table();

endpackage

>>> rtl/shannon_entropy_accumulator.sv
// channel   direction  handshake         word
// item      in         push / full       probability (Q1.16), last_entry
// result    out        pop / empty       entropy (Q8.16), saturated
//
// one probability word is taken per cycle unless full; the term path is lookup,
// multiply, add; a result passes the queue, s1, s2 and output registers in turn
// synchronous reset clears the queue, pipeline valids and the running sum
// while a result waits unpopped the back end holds; the four-word queue keeps
// taking input words until it fills
`include "shannon_entropy_accumulator_macros.svh"

module shannon_entropy_accumulator import sea_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  sea_in_t  item,
  input  logic     pop,
  output logic     empty,
  output sea_out_t result
);

  sea_work_t   work_in;
  sea_work_t   work_out;
  sea_q_stat_t q_stat;
  logic        q_wr;
  logic        q_pop;

  sea_front u_front (
    .push   (push),
    .item   (item),
    .q_full (q_stat.full),
    .full   (full),
    .wr     (q_wr),
    .work   (work_in)
  );

  sea_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (work_in),
    .rd      (q_pop),
    .rd_data (work_out),
    .stat    (q_stat)
  );

  sea_back u_back (
    .clk    (clk),
    .rst    (rst),
    .work   (work_out),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  `SEA_ASSERT_IMP(a_sat_all_ones, clk, rst, !empty && result.saturated, result.entropy == '1)
  `SEA_ASSERT_IMP(a_hold_no_pop, clk, rst, !empty && !pop, !q_pop)
  `SEA_ASSERT_IMP(a_queue_sane, clk, rst, q_stat.full, !q_stat.empty)
  `SEA_ASSERT_NXT(a_push_fills, clk, rst, push && !full && !q_pop, !q_stat.empty)

endmodule

>>> rtl/sea_front.sv
module sea_front import sea_pkg::*; (
  input  logic      push,
  input  sea_in_t   item,
  input  logic      q_full,
  output logic      full,
  output logic      wr,
  output sea_work_t work
);

  logic [PROB_FRAC_BITS-1:0] frac;
  logic                      active;
  logic [EXP_W-1:0]          lead;
  logic [NORM_W-1:0]         norm;

  assign frac   = item.probability[PROB_FRAC_BITS-1:0];
  // zero and anything at or above one add nothing
  assign active = (frac != '0) && !item.probability[PROB_FRAC_BITS];

  always_comb begin
    lead = '0;
    for (int i = 0; i < PROB_FRAC_BITS; i++) begin
      if (frac[i]) begin
        lead = EXP_W'(i);
      end
    end
  end

  // leading one moves to the top, table index sits just below it
  assign norm = {frac, {LOG_TABLE_BITS{1'b0}}}
                << (EXP_W'(PROB_FRAC_BITS - 1) - lead);

  always_comb begin
    work.prob     = active ? frac : '0;
    work.int_part = EXP_W'(PROB_FRAC_BITS) - lead;
    work.idx      = norm[NORM_W-2 -: LOG_TABLE_BITS];
    work.last     = item.last_entry;
  end

  assign full = q_full;
  assign wr   = push && !q_full;

endmodule

>>> rtl/sea_queue.sv
module sea_queue import sea_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr,
  input  sea_work_t   wr_data,
  input  logic        rd,
  output sea_work_t   rd_data,
  output sea_q_stat_t stat
);

  sea_work_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_wr      = wr && !stat.full;
  assign do_rd      = rd && !stat.empty;
  assign rd_data    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> rtl/sea_back.sv
module sea_back import sea_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  sea_work_t   work,
  input  sea_q_stat_t q_stat,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output sea_out_t    result
);

  localparam logic [SUM_W:0] SUM_CAP = {{(SUM_W - ENT_W){1'b0}}, 1'b1, {ENT_W{1'b0}}};
  localparam logic [SUM_W:0] OUT_MAX = {{(SUM_W + 1 - ENT_W){1'b0}}, {ENT_W{1'b1}}};

  logic                      adv;
  logic                      v1;
  logic [PROB_FRAC_BITS-1:0] s1_prob;
  logic [NEGLOG_W-1:0]       s1_neglog;
  logic                      s1_last;
  logic                      v2;
  logic [NEGLOG_W-1:0]       s2_term;
  logic                      s2_last;
  logic [SUM_W-1:0]          sum;
  logic                      out_valid;
  sea_out_t                  out_data;

  logic [NEGLOG_W-1:0]       neglog;
  logic [PROD_W-1:0]         prod;
  logic [SUM_W:0]            sum_raw;
  logic [SUM_W:0]            sum_sat;
  sea_out_t                  res_next;

  // whole back end holds while a result waits unpopped
  assign adv   = !out_valid || pop;
  assign q_pop = adv && !q_stat.empty;

  assign neglog = {work.int_part, {LOG_FRAC{1'b0}}}
                  - NEGLOG_W'(LOG_TABLE[work.idx]);
  assign prod   = PROD_W'(s1_prob) * PROD_W'(s1_neglog);

  always_comb begin
    sum_raw = (SUM_W+1)'(sum) + (SUM_W+1)'(s2_term);
    sum_sat = (sum_raw > SUM_CAP) ? SUM_CAP : sum_raw;
    if (sum_sat > OUT_MAX) begin
      res_next.entropy   = '1;
      res_next.saturated = 1'b1;
    end else begin
      res_next.entropy   = sum_sat[ENT_W-1:0];
      res_next.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= !q_stat.empty;
      v2        <= v1;
      out_valid <= v2 && s2_last;
      if (v2) begin
        sum <= s2_last ? '0 : sum_sat[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prob   <= work.prob;
      s1_neglog <= neglog;
      s1_last   <= work.last;
      s2_term   <= prod[PROD_W-1 -: NEGLOG_W];
      s2_last   <= s1_last;
      if (v2 && s2_last) begin
        out_data <= res_next;
      end
    end
  end

  assign empty  = !out_valid;
  assign result = out_data;

endmodule

>>> tb/shannon_entropy_accumulator_tb.sv
module shannon_entropy_accumulator_tb;
  import sea_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TARGET_WORDS = 1800;
  localparam int CALM_WORDS   = 250;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [63:0] SUM_CAP = 64'd1 << ENT_W;
  localparam logic [63:0] OUT_MAX = SUM_CAP - 64'd1;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  logic     full;
  logic     empty;
  sea_in_t  item = '0;
  sea_out_t result;

  sea_in_t  pending_words[$];
  sea_out_t entropy_due[$];
  logic [LOG_FRAC-1:0] lg2_frac [TBL_SIZE];
  logic [SUM_W-1:0]    ent_sum = '0;

  int  total_words = 0;
  int  accepted_words = 0;
  int  results_checked = 0;
  int  saturated_seen = 0;
  int  errors = 0;
  int  cycles = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  word_taken = 1'b0;

  shannon_entropy_accumulator DUT (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  always #1 clk = ~clk;

  // log2(1 + k/2^T) in q.16, rounded, by repeated squaring of a q2.62 value
  function automatic logic [LOG_FRAC-1:0] log_frac_entry(int unsigned k);
    logic [63:0]  x;
    logic [127:0] sq;
    logic [31:0]  r;
    int           i;
    x = (64'd1 << 62) + (64'(k) << (62 - LOG_TABLE_BITS));
    r = '0;
    for (i = 0; i < 24; i++) begin
      sq = {64'd0, x} * {64'd0, x};
      x  = 64'(sq >> 62);
      r  = r << 1;
      if (x[63]) begin
        r = r | 32'd1;
        x = x >> 1;
      end
    end
    r = (r + 32'd128) >> 8;
    if (r > 32'hFFFF) begin
      r = 32'hFFFF;
    end
    return r[LOG_FRAC-1:0];
  endfunction

  // -p*log2(p) in q.16, zero for p of zero or at least one
  function automatic logic [63:0] plogp_term(logic [PROB_W-1:0] p);
    int          e;
    int          i;
    logic [63:0] m;
    logic [63:0] k;
    logic [63:0] neglog;
    if (p == '0 || 64'(p) >= (64'd1 << PROB_FRAC_BITS)) begin
      return 64'd0;
    end
    e = 0;
    for (i = 0; i < PROB_FRAC_BITS; i++) begin
      if (p[i]) begin
        e = i;
      end
    end
    m = 64'(p) - (64'd1 << e);
    if (e >= LOG_TABLE_BITS) begin
      k = m >> (e - LOG_TABLE_BITS);
    end else begin
      k = m << (LOG_TABLE_BITS - e);
    end
    k = k & 64'(TBL_SIZE - 1);
    neglog = (64'(PROB_FRAC_BITS - e) << LOG_FRAC) - 64'(lg2_frac[k[LOG_TABLE_BITS-1:0]]);
    return (64'(p) * neglog) >> PROB_FRAC_BITS;
  endfunction

  function automatic void absorb_word(sea_in_t w);
    logic [63:0] s;
    sea_out_t    r;
    s = 64'(ent_sum) + plogp_term(w.probability);
    if (s > SUM_CAP) begin
      s = SUM_CAP;
    end
    ent_sum = s[SUM_W-1:0];
    if (w.last_entry) begin
      if (s > OUT_MAX) begin
        r.entropy   = '1;
        r.saturated = 1'b1;
      end else begin
        r.entropy   = s[ENT_W-1:0];
        r.saturated = 1'b0;
      end
      entropy_due.push_back(r);
      ent_sum = '0;
    end
  endfunction

  function automatic void add_word(int unsigned p, bit last);
    sea_in_t w;
    w.probability = p[PROB_W-1:0];
    w.last_entry  = last;
    pending_words.push_back(w);
  endfunction

  // one vector: mostly a proper distribution, otherwise arbitrary words
  function automatic void add_vector();
    int          len;
    int          i;
    int unsigned rem;
    int unsigned v;
    int          kind;
    len = $urandom_range(1, 8);
    if ($urandom_range(0, 9) < 7) begin
      rem = 65536;
      for (i = 0; i < len - 1; i++) begin
        v = $urandom_range(0, rem);
        rem -= v;
        add_word(v, 1'b0);
      end
      add_word(rem, 1'b1);
    end else begin
      for (i = 0; i < len; i++) begin
        kind = $urandom_range(0, 7);
        case (kind)
          0: v = 0;
          1: v = 65536;
          2: v = $urandom_range(65537, 131071);
          3: v = $urandom_range(1, 511);
          default: v = $urandom_range(0, 131071);
        endcase
        add_word(v, i == len - 1);
      end
    end
  endfunction

  // long vector of terms near the peak of -p*log2(p), pushes the sum past the range
  function automatic void add_saturating_vector();
    int i;
    for (i = 0; i < 520; i++) begin
      add_word($urandom_range(20000, 28000), i == 519);
    end
  endfunction

  // sampling and checking at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
    word_taken <= !rst && push && !full;
    if (!rst && push && !full) begin
      absorb_word(item);
      accepted_words <= accepted_words + 1;
    end
    if (!rst && pop && !empty) begin
      if (entropy_due.size() == 0) begin
        $error("unexpected result word: entropy %0d saturated %0d",
               result.entropy, result.saturated);
        errors++;
      end else begin
        if (result.entropy !== entropy_due[0].entropy) begin
          $error("entropy mismatch: expected %0d, actual %0d",
                 entropy_due[0].entropy, result.entropy);
          errors++;
        end
        if (result.saturated !== entropy_due[0].saturated) begin
          $error("saturated mismatch: expected %0d, actual %0d",
                 entropy_due[0].saturated, result.saturated);
          errors++;
        end
        if (entropy_due[0].saturated) begin
          saturated_seen++;
        end
        void'(entropy_due.pop_front());
      end
      results_checked++;
    end
  end

  // sender: holds an offered word until it is taken
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (word_taken) begin
        void'(pending_words.pop_front());
      end
      if (push && !word_taken) begin
        push <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (pending_words.size() == 0) begin
        push <= 1'b0;
      end else if (pending_words.size() > CALM_WORDS && $urandom_range(0, 11) == 0) begin
        send_gap = $urandom_range(1, 18) - 1;
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        item <= pending_words[0];
      end
    end
  end

  // receiver: random gaps plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (!hold_done && accepted_words >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      pop <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      pop <= 1'b0;
    end else if (pending_words.size() > CALM_WORDS && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(1, 18) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    bit sat_added;
    sat_added = 1'b0;
    for (int k = 0; k < TBL_SIZE; k++) begin
      lg2_frac[k] = log_frac_entry(k);
    end

    // zero, one and above one alone
    add_word(0, 1'b1);
    add_word(65536, 1'b1);
    add_word(131071, 1'b1);
    // small values take the left-shift index path, large ones the right shift
    add_word(65537, 1'b0);
    add_word(1, 1'b0);
    add_word(2, 1'b0);
    add_word(3, 1'b0);
    add_word(255, 1'b0);
    add_word(256, 1'b0);
    add_word(257, 1'b0);
    add_word(32768, 1'b0);
    add_word(65535, 1'b1);
    add_word(24109, 1'b0);
    add_word(40000, 1'b0);
    add_word(1000, 1'b0);
    add_word(0, 1'b0);
    add_word(98304, 1'b1);
    // uniform over four, then a fair coin
    repeat (3) add_word(16384, 1'b0);
    add_word(16384, 1'b1);
    add_word(32768, 1'b0);
    add_word(32768, 1'b1);

    while (pending_words.size() < TARGET_WORDS) begin
      if (!sat_added && pending_words.size() > 700) begin
        add_saturating_vector();
        sat_added = 1'b1;
      end
      add_vector();
    end
    total_words = pending_words.size();

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    wait (accepted_words == total_words);
    wait (entropy_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d probability words sent, %0d entropy words checked (%0d saturated)",
             accepted_words, results_checked, saturated_seen);
    $display("covered zero, one and above-one words, both index paths, and a long input stall");
    if (errors == 0 && entropy_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sea_pkg.sv
rtl/sea_front.sv
rtl/sea_queue.sv
rtl/sea_back.sv
rtl/shannon_entropy_accumulator.sv
tb/shannon_entropy_accumulator_tb.sv
